// ===== design/aesc_pkg.sv =====
// Shared types and constants for the arithmetic expression syntax checker.
package aesc_pkg;

    // Deepest bracket nesting that is counted before an overflow error.
    localparam int unsigned MAX_DEPTH = 255;
    localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Character classes for the neighbour pair checks.
    typedef enum logic [2:0] {
        CLS_OP     = 3'd0,
        CLS_ZERO   = 3'd1,
        CLS_DIGIT  = 3'd2,
        CLS_MULDIV = 3'd3,
        CLS_OPEN   = 3'd4,
        CLS_CLOSE  = 3'd5
    } t_class;

    // One input transaction as held in the input register.
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       line_end;
    } t_item;

    // Decoded view of one byte.
    typedef struct packed {
        t_class cls;
        logic   ok;
        logic   space;
    } t_char_info;

endpackage

// ===== design/aesc_classify.sv =====
// Byte decoder: character class, legality and space detection.
module aesc_classify
    import aesc_pkg::*;
(
    input  logic [7:0] i_char_code,
    output t_char_info o_info
);

    always_comb begin
        o_info.cls   = CLS_OP;
        o_info.ok    = 1'b1;
        o_info.space = (i_char_code == CH_SPACE);
        if (i_char_code == CH_ZERO) begin
            o_info.cls = CLS_ZERO;
        end else if (i_char_code >= CH_ONE && i_char_code <= CH_NINE) begin
            o_info.cls = CLS_DIGIT;
        end else if (i_char_code == CH_STAR || i_char_code == CH_SLASH) begin
            o_info.cls = CLS_MULDIV;
        end else if (i_char_code == CH_OPEN) begin
            o_info.cls = CLS_OPEN;
        end else if (i_char_code == CH_CLOSE) begin
            o_info.cls = CLS_CLOSE;
        end else if (i_char_code == CH_PLUS || i_char_code == CH_MINUS
                     || i_char_code == CH_UNDER || i_char_code == CH_SPACE) begin
            o_info.cls = CLS_OP;
        end else begin
            o_info.ok = 1'b0;
        end
    end

endmodule

// ===== design/aesc_line_state.sv =====
// Per-line state (previous class, space flag, depth, sticky error) and verdict.
module aesc_line_state
    import aesc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  t_item      i_item,
    input  t_char_info i_info,
    output logic       o_malformed,
    output logic       o_depth_zero
);

    t_class               r_prev_class, n_prev_class;
    logic                 r_space_seen, n_space_seen;
    logic [DEPTH_W-1:0]   r_open_depth, n_open_depth;
    logic                 r_error_seen, n_error_seen;

    logic bad_pair;
    logic ends_ok;

    always_comb begin
        bad_pair = 1'b0;
        case (r_prev_class)
            CLS_CLOSE:  bad_pair = (i_info.cls == CLS_DIGIT);
            CLS_MULDIV: bad_pair = (i_info.cls == CLS_CLOSE) || (i_info.cls == CLS_MULDIV);
            CLS_OPEN:   bad_pair = (i_info.cls == CLS_MULDIV);
            CLS_DIGIT:  bad_pair = (i_info.cls == CLS_OPEN)
                                   || ((i_info.cls == CLS_DIGIT) && r_space_seen);
            default:    bad_pair = 1'b0;
        endcase
    end

    always_comb begin
        n_prev_class = r_prev_class;
        n_space_seen = r_space_seen;
        n_open_depth = r_open_depth;
        n_error_seen = r_error_seen;
        if (i_item.has_char) begin
            if (i_info.space) begin
                n_space_seen = 1'b1;
            end else begin
                if (!i_info.ok || bad_pair) begin
                    n_error_seen = 1'b1;
                end
                if (i_info.cls == CLS_OPEN) begin
                    if (r_open_depth >= DEPTH_W'(MAX_DEPTH)) begin
                        n_error_seen = 1'b1;
                    end else begin
                        n_open_depth = r_open_depth + DEPTH_W'(1);
                    end
                end else if (i_info.cls == CLS_CLOSE) begin
                    if (r_open_depth == '0) begin
                        n_error_seen = 1'b1;
                    end else begin
                        n_open_depth = r_open_depth - DEPTH_W'(1);
                    end
                end
                n_prev_class = i_info.cls;
                n_space_seen = 1'b0;
            end
        end
        ends_ok     = (n_prev_class == CLS_ZERO) || (n_prev_class == CLS_DIGIT)
                      || (n_prev_class == CLS_CLOSE);
        o_malformed = n_error_seen || (n_open_depth != '0) || !ends_ok;
        if (i_item.line_end) begin
            n_prev_class = CLS_OP;
            n_space_seen = 1'b0;
            n_open_depth = '0;
            n_error_seen = 1'b0;
        end
    end

    assign o_depth_zero = (r_open_depth == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_class <= CLS_OP;
            r_space_seen <= 1'b0;
            r_open_depth <= '0;
            r_error_seen <= 1'b0;
        end else if (i_advance) begin
            r_prev_class <= n_prev_class;
            r_space_seen <= n_space_seen;
            r_open_depth <= n_open_depth;
            r_error_seen <= n_error_seen;
        end
    end

endmodule

// ===== design/arith_expression_syntax_check_top.sv =====
// Top level of the arithmetic expression syntax checker.
//
// The checker takes an expression one byte per input transaction and returns
// one result transaction, the malformed flag, for each transaction marked
// line_end; other transactions return nothing. A transaction with has_char low
// carries no byte, so an end marker alone closes an empty line (reported as
// malformed). Throughput is one transaction per clock while o_in_stall is low:
// the only feedback loop is the per-line state update. An accepted end-of-line
// transaction reaches the result through the input register, then the result
// register. The result register frees the input side: bytes that do not end a
// line keep flowing while a verdict waits to be taken; only a second line end
// has to wait for the result register. Bracket nesting is counted up to
// MAX_DEPTH in the package; a deeper open bracket flags the line.
module arith_expression_syntax_check_top
    import aesc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_has_char,
    input  logic       i_line_end,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_malformed
);

    // Input register
    logic  r_s1_valid;
    t_item r_s1;

    // Result register
    logic  r_out_valid;
    logic  r_malformed;

    t_char_info info;
    logic       malformed;
    logic       depth_zero;
    logic       out_free;
    logic       s1_adv;
    logic       in_take;

    // The result register can load when it is empty or being emptied.
    assign out_free = !r_out_valid || !i_out_stall;
    // Bytes mid-line never need the result register.
    assign s1_adv   = r_s1_valid && (!r_s1.line_end || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_take  = i_in_valid && !o_in_stall;

    aesc_classify u_classify (
        .i_char_code (r_s1.char_code),
        .o_info      (info)
    );

    aesc_line_state u_line_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (s1_adv),
        .i_item       (r_s1),
        .i_info       (info),
        .o_malformed  (malformed),
        .o_depth_zero (depth_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1.line_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1.char_code <= i_char_code;
            r_s1.has_char  <= i_has_char;
            r_s1.line_end  <= i_line_end;
        end
        if (s1_adv && r_s1.line_end) begin
            r_malformed <= malformed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_malformed = r_malformed;

    // A new verdict only appears after a line end left the input register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(s1_adv && r_s1.line_end))
        else $error("result appeared without a line end");

    // A waiting verdict is never overwritten by the next line end.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(s1_adv && r_s1.line_end))
        else $error("pending result overwritten");

    // Every line leaves the bracket counter cleared.
    a_depth_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1.line_end) |=> depth_zero)
        else $error("bracket depth not cleared at line end");

    // Input is held back only when the input register holds a line end while a verdict waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s1.line_end && r_out_valid))
        else $error("input stalled without a pending line end");

endmodule
